// ===== hdl/fcte_pkg.sv =====
package fcte_pkg;

	localparam int CACHE_SLOTS_DEF = 32;
	localparam int IDX_W = 6;
	localparam int CNT_W = 6;
	localparam int MS_PER_S = 1000;

	localparam logic [1:0] REG_ACTIVE_TO = 2'd0;
	localparam logic [1:0] REG_INACTIVE_TO = 2'd1;
	localparam logic [1:0] REG_CACHE_LIMIT = 2'd2;

	localparam logic [7:0] FLAG_FIN = 8'h01;
	localparam logic [7:0] FLAG_RST = 8'h04;

	typedef struct packed {
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [7:0]  protocol;
		logic [7:0]  tos;
	} flow_key_t;

	typedef struct packed {
		flow_key_t   key;
		logic [31:0] packets;
		logic [31:0] octets;
		logic [31:0] first;
		logic [31:0] last;
		logic [7:0]  flags;
	} flow_rec_t;

	// Packet context shared by every cell of the row.
	typedef struct packed {
		flow_key_t   key;
		logic [15:0] octets;
		logic [7:0]  flags;
		logic [31:0] uptime;
		logic [31:0] t_active;
		logic [31:0] t_inactive;
	} pkt_ctx_t;

	// Word handed from cell to cell during a search pass.
	typedef struct packed {
		logic             go;
		logic             old_found;
		logic [31:0]      old_first;
		logic [IDX_W-1:0] old_idx;
		logic             hit_found;
		logic [IDX_W-1:0] hit_idx;
		logic             free_found;
		logic [IDX_W-1:0] free_idx;
		logic [CNT_W-1:0] count;
	} chain_t;

endpackage

// ===== hdl/fcte_pkt_if.sv =====
interface fcte_pkt_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [31:0] src_addr;
	logic [31:0] dst_addr;
	logic [15:0] src_port;
	logic [15:0] dst_port;
	logic [7:0]  protocol;
	logic [7:0]  tos;
	logic [7:0]  flag_byte;
	logic [15:0] octets;
	logic [31:0] time_ms;

	modport source (output valid, cmd, src_addr, dst_addr, src_port, dst_port, protocol,
		tos, flag_byte, octets, time_ms, input ready);
	modport sink (input valid, cmd, src_addr, dst_addr, src_port, dst_port, protocol,
		tos, flag_byte, octets, time_ms, output ready);
endinterface

// ===== hdl/fcte_rec_if.sv =====
interface fcte_rec_if;
	logic        valid;
	logic        ready;
	logic [31:0] rec_src_addr;
	logic [31:0] rec_dst_addr;
	logic [15:0] rec_src_port;
	logic [15:0] rec_dst_port;
	logic [7:0]  rec_protocol;
	logic [7:0]  rec_tos;
	logic [31:0] rec_packets;
	logic [31:0] rec_octets;
	logic [31:0] rec_first;
	logic [31:0] rec_last;
	logic [7:0]  rec_flags;
	logic        end_of_run;

	modport source (output valid, rec_src_addr, rec_dst_addr, rec_src_port, rec_dst_port,
		rec_protocol, rec_tos, rec_packets, rec_octets, rec_first, rec_last, rec_flags,
		end_of_run, input ready);
	modport sink (input valid, rec_src_addr, rec_dst_addr, rec_src_port, rec_dst_port,
		rec_protocol, rec_tos, rec_packets, rec_octets, rec_first, rec_last, rec_flags,
		end_of_run, output ready);
endinterface

// ===== hdl/fcte_cell.sv =====
module fcte_cell #(
	parameter int SLOT = 0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  fcte_pkg::pkt_ctx_t ctx,
	input  logic               clr,
	input  logic               load,
	input  logic               upd,
	input  fcte_pkg::chain_t   chain_in,
	output fcte_pkg::chain_t   chain_out,
	output fcte_pkg::flow_rec_t rec,
	output logic               valid,
	output logic               expired
);
	import fcte_pkg::*;

	logic      valid_q;
	flow_rec_t rec_q;
	chain_t    chain_q;
	chain_t    chain_d;
	logic      match;

	assign valid = valid_q;
	assign rec = rec_q;
	assign chain_out = chain_q;
	assign match = valid_q && (rec_q.key == ctx.key);

	// A flow times out when its start or its last packet lies too far back.
	assign expired = (ctx.t_active < ctx.uptime && rec_q.first < ctx.uptime - ctx.t_active) ||
		(ctx.t_inactive < ctx.uptime && rec_q.last < ctx.uptime - ctx.t_inactive);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (clr) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rec_q.key <= ctx.key;
			rec_q.packets <= 32'd1;
			rec_q.octets <= 32'(ctx.octets);
			rec_q.first <= ctx.uptime;
			rec_q.last <= ctx.uptime;
			rec_q.flags <= ctx.flags;
		end else if (upd) begin
			rec_q.packets <= rec_q.packets + 32'd1;
			rec_q.octets <= rec_q.octets + 32'(ctx.octets);
			rec_q.last <= ctx.uptime;
			rec_q.flags <= rec_q.flags | ctx.flags;
		end
	end

	// Strict compare keeps the lower slot on equal start times.
	always_comb begin
		chain_d = chain_in;
		if (chain_in.go) begin
			if (valid_q && (!chain_in.old_found || rec_q.first < chain_in.old_first)) begin
				chain_d.old_found = 1'b1;
				chain_d.old_first = rec_q.first;
				chain_d.old_idx = IDX_W'(SLOT);
			end
			if (!chain_in.hit_found && match) begin
				chain_d.hit_found = 1'b1;
				chain_d.hit_idx = IDX_W'(SLOT);
			end
			if (!chain_in.free_found && !valid_q) begin
				chain_d.free_found = 1'b1;
				chain_d.free_idx = IDX_W'(SLOT);
			end
			chain_d.count = chain_in.count + CNT_W'(valid_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= '0;
		end else begin
			chain_q <= chain_d;
		end
	end
endmodule

// ===== hdl/flow_cache_timeout_export_top.sv =====
// Flow cache with timeout export, one flow per cell in a row of cells.
// Input channel pkt carries one word per packet (cmd 0) or a flush request
// (cmd 1). Output channel rec carries one word per exported flow; the last
// word caused by an input has end_of_run set. The configuration port writes
// the active timeout, the inactive timeout and the cache limit by index.
// Packets are taken one at a time: pkt.ready is high only while the block
// is idle. A packet first runs a timeout sweep over all CACHE_SLOTS slots
// (one slot per cycle, unless an export waits on the receiver), then a pass of the
// search word along the cell row (one pass, two when a flow is evicted,
// with an export step for the eviction itself), then the apply, check and
// finish states, which apply the packet and finish. A flush takes (k + 1)
// search passes for k cached flows. The row of cells paces the search
// passes: each search moves one cell per cycle.
// Reset empties the cache and restores the register defaults. When the
// receiver stalls, the block holds its current record and waits; nothing is
// dropped.
module flow_cache_timeout_export_top #(
	parameter int CACHE_SLOTS = fcte_pkg::CACHE_SLOTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_idx,
	input  logic [15:0]       cfg_data,
	fcte_pkt_if.sink          pkt,
	fcte_rec_if.source        rec
);
	import fcte_pkg::*;

	localparam int IW = $clog2(CACHE_SLOTS);

	typedef enum logic [3:0] {
		ST_IDLE, ST_SWEEP, ST_SEARCH_GO, ST_SEARCH_WAIT, ST_EMIT_OLD, ST_APPLY, ST_CHECK,
		ST_FINISH
	} state_t;

	state_t     state_q;
	logic [15:0] act_to_q, inact_to_q;
	logic [5:0]  limit_q;
	logic        boot_seen_q;
	logic [31:0] boot_time_q;
	pkt_ctx_t    ctx_q;
	logic        flush_q, evict_phase_q;
	logic [IW-1:0] sweep_q, sel_q;
	chain_t      res_q;

	chain_t    chain [CACHE_SLOTS+1];
	flow_rec_t cell_rec [CACHE_SLOTS];
	logic [CACHE_SLOTS-1:0] cell_valid, cell_exp, clr_vec, load_vec, upd_vec;
	logic        launch, do_load, do_upd;
	logic [IW-1:0] wr_idx;

	// Output side: a held record waits until it is known whether it ends the run.
	flow_rec_t hold_q, out_q;
	logic      hold_v_q, out_v_q, out_eor_q;
	logic      can_emit, emit_go;
	logic [IW-1:0] emit_idx;
	logic [31:0] now_up;

	assign can_emit = !out_v_q || rec.ready;

	always_comb begin
		chain[0] = '0;
		chain[0].go = launch;
	end

	for (genvar i = 0; i < CACHE_SLOTS; i++) begin : g_cell
		fcte_cell #(.SLOT(i)) u_cell (
			.clk(clk), .arst_n(arst_n), .ctx(ctx_q),
			.clr(clr_vec[i]), .load(load_vec[i]), .upd(upd_vec[i]),
			.chain_in(chain[i]), .chain_out(chain[i+1]),
			.rec(cell_rec[i]), .valid(cell_valid[i]), .expired(cell_exp[i])
		);
		assign clr_vec[i] = emit_go && (emit_idx == IW'(i));
		assign load_vec[i] = do_load && (wr_idx == IW'(i));
		assign upd_vec[i] = do_upd && (wr_idx == IW'(i));
	end

	// Select which slot is exported this cycle, if any, and drive the search launch and the cell writes.
	always_comb begin
		emit_go = 1'b0;
		emit_idx = sweep_q;
		launch = 1'b0;
		do_load = 1'b0;
		do_upd = 1'b0;
		wr_idx = res_q.hit_idx[IW-1:0];
		unique case (state_q)
			ST_SWEEP: begin
				emit_idx = sweep_q;
				emit_go = cell_valid[sweep_q] && cell_exp[sweep_q] && can_emit;
			end
			ST_EMIT_OLD: begin
				emit_idx = res_q.old_idx[IW-1:0];
				emit_go = can_emit;
			end
			ST_CHECK: begin
				emit_idx = sel_q;
				emit_go = |(cell_rec[sel_q].flags & (FLAG_FIN | FLAG_RST)) && can_emit;
			end
			ST_SEARCH_GO: launch = 1'b1;
			ST_APPLY: begin
				do_upd = res_q.hit_found;
				do_load = !res_q.hit_found && res_q.free_found;
				wr_idx = res_q.hit_found ? res_q.hit_idx[IW-1:0] : res_q.free_idx[IW-1:0];
			end
			default: ;
		endcase
	end

	assign now_up = boot_seen_q ? pkt.time_ms - boot_time_q : 32'd0;
	assign pkt.ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_to_q <= 16'd60;
			inact_to_q <= 16'd10;
			limit_q <= 6'd32;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_ACTIVE_TO:   act_to_q <= cfg_data;
				REG_INACTIVE_TO: inact_to_q <= cfg_data;
				REG_CACHE_LIMIT: limit_q <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			boot_seen_q <= 1'b0;
			boot_time_q <= '0;
			flush_q <= 1'b0;
			evict_phase_q <= 1'b0;
			sweep_q <= '0;
			sel_q <= '0;
			res_q <= '0;
			ctx_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (pkt.valid) begin
						ctx_q.key <= '{pkt.src_addr, pkt.dst_addr, pkt.src_port,
							pkt.dst_port, pkt.protocol, pkt.tos};
						ctx_q.octets <= pkt.octets;
						ctx_q.flags <= pkt.flag_byte;
						ctx_q.uptime <= now_up;
						ctx_q.t_active <= 32'(act_to_q) * 32'(MS_PER_S);
						ctx_q.t_inactive <= 32'(inact_to_q) * 32'(MS_PER_S);
						sweep_q <= '0;
						flush_q <= pkt.cmd;
						if (pkt.cmd) begin
							state_q <= ST_SEARCH_GO;
						end else begin
							if (!boot_seen_q) begin
								boot_seen_q <= 1'b1;
								boot_time_q <= pkt.time_ms;
							end
							state_q <= ST_SWEEP;
						end
					end
				end
				ST_SWEEP: begin
					if (!(cell_valid[sweep_q] && cell_exp[sweep_q]) || can_emit) begin
						if (sweep_q == IW'(CACHE_SLOTS - 1)) begin
							evict_phase_q <= 1'b1;
							state_q <= ST_SEARCH_GO;
						end else begin
							sweep_q <= sweep_q + 1'b1;
						end
					end
				end
				ST_SEARCH_GO: state_q <= ST_SEARCH_WAIT;
				ST_SEARCH_WAIT: begin
					if (chain[CACHE_SLOTS].go) begin
						res_q <= chain[CACHE_SLOTS];
						if (flush_q) begin
							state_q <= chain[CACHE_SLOTS].old_found ? ST_EMIT_OLD : ST_FINISH;
						end else if (evict_phase_q && chain[CACHE_SLOTS].old_found &&
							(chain[CACHE_SLOTS].count >= limit_q ||
							chain[CACHE_SLOTS].count >= CNT_W'(CACHE_SLOTS))) begin
							state_q <= ST_EMIT_OLD;
						end else begin
							state_q <= ST_APPLY;
						end
					end
				end
				ST_EMIT_OLD: begin
					if (can_emit) begin
						evict_phase_q <= 1'b0;
						state_q <= ST_SEARCH_GO;
					end
				end
				ST_APPLY: begin
					sel_q <= wr_idx;
					state_q <= (res_q.hit_found || res_q.free_found) ? ST_CHECK : ST_FINISH;
				end
				ST_CHECK: begin
					if (!(|(cell_rec[sel_q].flags & (FLAG_FIN | FLAG_RST))) || can_emit) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (!hold_v_q || can_emit) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output staging: an exported flow is held back in hold_q so that end_of_run
	// can be set on the last word once the input is finished.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q <= 1'b0;
			out_v_q <= 1'b0;
			out_eor_q <= 1'b0;
		end else begin
			if (emit_go) begin
				hold_v_q <= 1'b1;
				if (hold_v_q) begin
					out_v_q <= 1'b1;
					out_eor_q <= 1'b0;
				end else if (rec.ready) begin
					out_v_q <= 1'b0;
				end
			end else if (state_q == ST_FINISH && hold_v_q && can_emit) begin
				hold_v_q <= 1'b0;
				out_v_q <= 1'b1;
				out_eor_q <= 1'b1;
			end else if (rec.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			hold_q <= cell_rec[emit_idx];
			if (hold_v_q) begin
				out_q <= hold_q;
			end
		end else if (state_q == ST_FINISH && hold_v_q && can_emit) begin
			out_q <= hold_q;
		end
	end

	assign rec.valid = out_v_q;
	assign rec.rec_src_addr = out_q.key.src_addr;
	assign rec.rec_dst_addr = out_q.key.dst_addr;
	assign rec.rec_src_port = out_q.key.src_port;
	assign rec.rec_dst_port = out_q.key.dst_port;
	assign rec.rec_protocol = out_q.key.protocol;
	assign rec.rec_tos = out_q.key.tos;
	assign rec.rec_packets = out_q.packets;
	assign rec.rec_octets = out_q.octets;
	assign rec.rec_first = out_q.first;
	assign rec.rec_last = out_q.last;
	assign rec.rec_flags = out_q.flags;
	assign rec.end_of_run = out_eor_q;
endmodule

// ===== verif/flow_cache_timeout_export_top_tb.sv =====
`timescale 1ns / 100ps

module flow_cache_timeout_export_top_tb;
	import fcte_pkg::*;

	// One word offered on the packet channel.
	typedef struct {
		logic        cmd;
		flow_key_t   key;
		logic [7:0]  flags;
		logic [15:0] octets;
		logic [31:0] time_ms;
	} pkt_word_t;

	// One exported flow as the record channel should carry it.
	typedef struct {
		flow_rec_t rec;
		logic      last_word;
	} export_word_t;

	// Keeps its own copy of the cache and registers and predicts the export words.
	class flow_export_board;
		logic [15:0]  active_s;
		logic [15:0]  inactive_s;
		logic [5:0]   limit;
		logic         boot_seen;
		logic [31:0]  boot_ms;
		logic         used [CACHE_SLOTS_DEF];
		flow_rec_t    slot [CACHE_SLOTS_DEF];
		export_word_t pending_exports[$];
		int           errors;

		function new();
			active_s = 16'd60;
			inactive_s = 16'd10;
			limit = 6'd32;
			boot_seen = 1'b0;
			boot_ms = '0;
			foreach (used[i]) used[i] = 1'b0;
			errors = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [15:0] data);
			case (idx)
				REG_ACTIVE_TO: active_s = data;
				REG_INACTIVE_TO: inactive_s = data;
				REG_CACHE_LIMIT: limit = data[5:0];
				default: ;
			endcase
		endfunction

		function void export_slot(int s);
			export_word_t w;
			w.rec = slot[s];
			w.last_word = 1'b0;
			pending_exports.push_back(w);
			used[s] = 1'b0;
		endfunction

		// Earliest start time wins, lowest slot on a tie.
		function int oldest_flow();
			int best;
			best = -1;
			for (int s = 0; s < CACHE_SLOTS_DEF; s++)
				if (used[s] && (best < 0 || slot[s].first < slot[best].first))
					best = s;
			return best;
		endfunction

		function bit timed_out(logic [31:0] stamp, logic [15:0] secs, logic [31:0] up);
			logic [31:0] t;
			t = secs * 32'd1000;
			return t < up && stamp < up - t;
		endfunction

		function void note_packet(pkt_word_t p);
			int start;
			int hit;
			int live;
			logic [31:0] up;
			start = pending_exports.size();
			hit = -1;
			live = 0;
			if (p.cmd) begin
				for (int s = oldest_flow(); s >= 0; s = oldest_flow())
					export_slot(s);
			end else begin
				if (!boot_seen) begin
					boot_seen = 1'b1;
					boot_ms = p.time_ms;
				end
				up = p.time_ms - boot_ms;
				for (int s = 0; s < CACHE_SLOTS_DEF; s++) begin
					if (!used[s])
						continue;
					if (timed_out(slot[s].first, active_s, up) ||
						timed_out(slot[s].last, inactive_s, up))
						export_slot(s);
					else
						live++;
				end
				if (live > 0 && (live >= limit || live >= CACHE_SLOTS_DEF))
					export_slot(oldest_flow());
				for (int s = 0; s < CACHE_SLOTS_DEF; s++)
					if (hit < 0 && used[s] && slot[s].key == p.key)
						hit = s;
				if (hit >= 0) begin
					slot[hit].packets = slot[hit].packets + 1;
					slot[hit].octets = slot[hit].octets + p.octets;
					slot[hit].last = up;
					slot[hit].flags = slot[hit].flags | p.flags;
				end else begin
					for (int s = 0; s < CACHE_SLOTS_DEF; s++)
						if (hit < 0 && !used[s])
							hit = s;
					if (hit >= 0) begin
						used[hit] = 1'b1;
						slot[hit].key = p.key;
						slot[hit].packets = 32'd1;
						slot[hit].octets = {16'd0, p.octets};
						slot[hit].first = up;
						slot[hit].last = up;
						slot[hit].flags = p.flags;
					end
				end
				if (hit >= 0 && (slot[hit].flags & (FLAG_FIN | FLAG_RST)) != 0)
					export_slot(hit);
			end
			if (pending_exports.size() > start)
				pending_exports[pending_exports.size() - 1].last_word = 1'b1;
		endfunction

		task report(string what, logic [31:0] got, logic [31:0] want);
			$display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
			errors++;
		endtask

		task check_record(flow_rec_t got, logic got_last);
			export_word_t w;
			if (pending_exports.size() == 0) begin
				report("unexpected export word", got.key.src_addr, 32'd0);
				return;
			end
			w = pending_exports.pop_front();
			if (got.key.src_addr !== w.rec.key.src_addr)
				report("rec_src_addr", got.key.src_addr, w.rec.key.src_addr);
			if (got.key.dst_addr !== w.rec.key.dst_addr)
				report("rec_dst_addr", got.key.dst_addr, w.rec.key.dst_addr);
			if (got.key.src_port !== w.rec.key.src_port)
				report("rec_src_port", 32'(got.key.src_port), 32'(w.rec.key.src_port));
			if (got.key.dst_port !== w.rec.key.dst_port)
				report("rec_dst_port", 32'(got.key.dst_port), 32'(w.rec.key.dst_port));
			if (got.key.protocol !== w.rec.key.protocol)
				report("rec_protocol", 32'(got.key.protocol), 32'(w.rec.key.protocol));
			if (got.key.tos !== w.rec.key.tos)
				report("rec_tos", 32'(got.key.tos), 32'(w.rec.key.tos));
			if (got.packets !== w.rec.packets)
				report("rec_packets", got.packets, w.rec.packets);
			if (got.octets !== w.rec.octets)
				report("rec_octets", got.octets, w.rec.octets);
			if (got.first !== w.rec.first)
				report("rec_first", got.first, w.rec.first);
			if (got.last !== w.rec.last)
				report("rec_last", got.last, w.rec.last);
			if (got.flags !== w.rec.flags)
				report("rec_flags", 32'(got.flags), 32'(w.rec.flags));
			if (got_last !== w.last_word)
				report("end_of_run", 32'(got_last), 32'(w.last_word));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_idx;
	logic [15:0] cfg_data;

	fcte_pkt_if pkt ();
	fcte_rec_if rec ();

	flow_export_board board;

	// Idle control shared by both sides: no_idle turns off random gaps and
	// stalls, rx_hold_cycles makes the receiver hold off for a long stretch.
	bit          no_idle;
	int          rx_hold_cycles;
	logic [31:0] now_ms;
	flow_key_t   key_pool[12];

	flow_cache_timeout_export_top i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_we),
		.cfg_idx (cfg_idx),
		.cfg_data(cfg_data),
		.pkt     (pkt.sink),
		.rec     (rec.source)
	);

	always #2 clk = ~clk;

	// Safety net against a hung block.
	initial begin
		#10_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// Record side. Words are checked at the edge that accepts them, and ready
	// for the next edge is decided once per edge.
	initial begin
		flow_rec_t r;
		rec.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rec.valid && rec.ready) begin
				r.key.src_addr = rec.rec_src_addr;
				r.key.dst_addr = rec.rec_dst_addr;
				r.key.src_port = rec.rec_src_port;
				r.key.dst_port = rec.rec_dst_port;
				r.key.protocol = rec.rec_protocol;
				r.key.tos = rec.rec_tos;
				r.packets = rec.rec_packets;
				r.octets = rec.rec_octets;
				r.first = rec.rec_first;
				r.last = rec.rec_last;
				r.flags = rec.rec_flags;
				board.check_record(r, rec.end_of_run);
			end
			if (rx_hold_cycles > 0) begin
				rx_hold_cycles--;
				rec.ready <= 1'b0;
			end else begin
				rec.ready <= no_idle || ($urandom_range(99) >= 23);
			end
		end
	end

	// Offer one word and wait for the block to take it. The valid line is
	// lowered only when a gap follows, so back-to-back words keep it high.
	task send_word(pkt_word_t p);
		pkt.valid <= 1'b1;
		pkt.cmd <= p.cmd;
		pkt.src_addr <= p.key.src_addr;
		pkt.dst_addr <= p.key.dst_addr;
		pkt.src_port <= p.key.src_port;
		pkt.dst_port <= p.key.dst_port;
		pkt.protocol <= p.key.protocol;
		pkt.tos <= p.key.tos;
		pkt.flag_byte <= p.flags;
		pkt.octets <= p.octets;
		pkt.time_ms <= p.time_ms;
		do
			@(posedge clk);
		while (!pkt.ready);
		board.note_packet(p);
		if (!no_idle && $urandom_range(99) < 23) begin
			pkt.valid <= 1'b0;
			repeat ($urandom_range(1, ($urandom_range(3) == 0) ? 90 : 5))
				@(posedge clk);
		end
	endtask

	task send_packet(flow_key_t k, logic [7:0] flags, logic [15:0] octets, int step_ms);
		pkt_word_t p;
		now_ms = now_ms + step_ms;
		p.cmd = 1'b0;
		p.key = k;
		p.flags = flags;
		p.octets = octets;
		p.time_ms = now_ms;
		send_word(p);
	endtask

	task send_flush();
		pkt_word_t p;
		p.cmd = 1'b1;
		p.key = '0;
		p.flags = '0;
		p.octets = '0;
		p.time_ms = '0;
		send_word(p);
	endtask

	// Wait until every predicted export word has come, then let the block
	// finish any packet that exported nothing.
	task drain();
		@(posedge clk);
		pkt.valid <= 1'b0;
		while (board.pending_exports.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task write_regs(logic [15:0] act, logic [15:0] inact, logic [15:0] lim);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= REG_ACTIVE_TO;
		cfg_data <= act;
		@(posedge clk);
		cfg_idx <= REG_INACTIVE_TO;
		cfg_data <= inact;
		@(posedge clk);
		cfg_idx <= REG_CACHE_LIMIT;
		cfg_data <= lim;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.write_reg(REG_ACTIVE_TO, act);
		board.write_reg(REG_INACTIVE_TO, inact);
		board.write_reg(REG_CACHE_LIMIT, lim);
	endtask

	function flow_key_t random_key();
		flow_key_t k;
		k.src_addr = $urandom;
		k.dst_addr = $urandom;
		k.src_port = 16'($urandom);
		k.dst_port = 16'($urandom);
		k.protocol = 8'($urandom);
		k.tos = 8'($urandom);
		return k;
	endfunction

	// One random phase: mostly packets of a small pool of flows so that
	// updates, timeouts and evictions all happen, plus stray flows and flushes.
	task random_phase(int count);
		int step;
		logic [7:0] flags;
		foreach (key_pool[i])
			key_pool[i] = random_key();
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(99) < 5) begin
				send_flush();
				continue;
			end
			case ($urandom_range(19))
				0: step = $urandom;
				1, 2, 3: step = $urandom_range(0, 20000);
				4, 5, 6, 7, 8, 9: step = $urandom_range(0, 1500);
				default: step = $urandom_range(0, 50);
			endcase
			flags = 8'($urandom);
			if ($urandom_range(99) < 85)
				flags = flags & ~(FLAG_FIN | FLAG_RST);
			send_packet(($urandom_range(99) < 80) ? key_pool[$urandom_range(11)] : random_key(),
				flags, 16'($urandom), step);
		end
		drain();
	endtask

	initial begin
		flow_key_t ones;
		flow_key_t zero;
		board = new();
		clk = 1'b0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_idx <= REG_ACTIVE_TO;
		cfg_data <= '0;
		pkt.valid <= 1'b0;
		pkt.cmd <= 1'b0;
		pkt.src_addr <= '0;
		pkt.dst_addr <= '0;
		pkt.src_port <= '0;
		pkt.dst_port <= '0;
		pkt.protocol <= '0;
		pkt.tos <= '0;
		pkt.flag_byte <= '0;
		pkt.octets <= '0;
		pkt.time_ms <= '0;
		no_idle = 1'b0;
		rx_hold_cycles = 0;
		ones = '1;
		zero = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed part under the reset defaults. The first packet sets the
		// boot time close to the wrap, so the second one's time wraps around.
		now_ms = 32'hFFFF_F000;
		send_packet(ones, 8'h00, 16'hFFFF, 0);
		send_packet(ones, 8'h00, 16'hFFFF, 32'h0000_1800);
		send_packet(zero, 8'hFA, 16'h0000, 1);
		send_packet(zero, FLAG_FIN, 16'h0001, 2);
		send_packet(random_key(), FLAG_RST, 16'h0040, 3);
		send_packet(random_key(), 8'h00, 16'h0040, 3);
		send_flush();
		send_flush();
		// An inactive timeout, then an active timeout of a busy flow.
		send_packet(zero, 8'h00, 16'h0010, 1000);
		send_packet(ones, 8'h00, 16'h0010, 10_001);
		for (int i = 0; i < 7; i++)
			send_packet(ones, 8'h00, 16'h0010, 9000);
		drain();

		// Zero timeouts and a limit of one: every older flow goes on each packet.
		write_regs(16'd0, 16'd0, 16'd1);
		send_packet(zero, 8'h00, 16'h0001, 0);
		send_packet(ones, 8'h00, 16'h0002, 0);
		send_packet(ones, 8'h00, 16'h0003, 1);
		drain();

		// A limit of zero evicts before every packet.
		write_regs(16'hFFFF, 16'hFFFF, 16'd0);
		send_packet(zero, 8'h00, 16'h0001, 5);
		send_packet(zero, 8'h00, 16'h0001, 5);
		send_flush();
		drain();

		// A limit beyond the slot count, with a long receiver hold-off so the
		// block fills up and stalls its input.
		write_regs(16'hFFFF, 16'hFFFF, 16'd63);
		rx_hold_cycles = 600;
		random_phase(50);
		send_flush();
		drain();

		write_regs(16'd60, 16'd10, 16'd32);
		random_phase(60);

		// A stretch with no gaps and no stalls on either side.
		no_idle = 1'b1;
		write_regs(16'd1, 16'd0, 16'd4);
		random_phase(60);
		no_idle = 1'b0;

		write_regs(16'd0, 16'd0, 16'd1);
		random_phase(40);

		write_regs(16'd5, 16'd2, 16'd32);
		random_phase(60);

		write_regs(16'd2, 16'd1, 16'd8);
		random_phase(60);

		write_regs(16'd30, 16'd3, 16'd16);
		random_phase(60);
		send_flush();
		drain();

		if (board.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
